// File: hdl/rdfm_pkg.sv
// Shared types, codes and helpers for the relay driver with feedback monitor.
// Used by rdfm_cfg_regs, rdfm_core and the top level; depends on nothing else.
`default_nettype none

package rdfm_pkg;

    // Field widths fixed by the item format.
    localparam int ACTION_W   = 3;
    localparam int INDEX_W    = 5;
    localparam int FIELD_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int DELAY_W    = 16;
    localparam int TYPES_W    = 16;
    localparam int ACTIVE_W   = 5;

    // Configuration port geometry.
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Action codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_SET          = 3'd0,
        ACT_TICK         = 3'd1,
        ACT_READ_CONTACT = 3'd2,
        ACT_READ_FAULT   = 3'd3,
        ACT_STOP         = 3'd4,
        ACT_START        = 3'd5
    } action_t;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_SETTLE_DELAY  = 2'd0,
        REG_CONTACT_TYPES = 2'd1,
        REG_ACTIVE_COUNT  = 2'd2
    } reg_index_t;

    // Contact status codes.
    localparam logic [STATUS_W-1:0] CONTACT_OPEN    = 2'd0;
    localparam logic [STATUS_W-1:0] CONTACT_CLOSED  = 2'd1;
    localparam logic [STATUS_W-1:0] CONTACT_ERROR   = 2'd2;
    localparam logic [STATUS_W-1:0] CONTACT_INVALID = 2'd3;

    // Fault status codes.
    localparam logic [STATUS_W-1:0] FAULT_NONE      = 2'd0;
    localparam logic [STATUS_W-1:0] FAULT_WELDED    = 2'd1;
    localparam logic [STATUS_W-1:0] FAULT_STUCK     = 2'd2;
    localparam logic [STATUS_W-1:0] FAULT_INVALID   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [DELAY_W-1:0]  SETTLE_DELAY_RST  = 16'd100;
    localparam logic [TYPES_W-1:0]  CONTACT_TYPES_RST = 16'd0;
    localparam logic [ACTIVE_W-1:0] ACTIVE_COUNT_RST  = 5'd16;

    // Configuration as seen by the core.
    typedef struct packed {
        logic [DELAY_W-1:0]  settle_delay;
        logic [TYPES_W-1:0]  contact_types;
        logic [ACTIVE_W-1:0] active_count;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [FIELD_W-1:0]  coil_drive;
        logic [STATUS_W-1:0] contact_status;
        logic [STATUS_W-1:0] fault_status;
    } result_t;

    // Fault class of a settled relay from coil, feedback and contact type.
    function automatic logic [STATUS_W-1:0] classify_fault(
        input logic coil,
        input logic fb,
        input logic ctype
    );
        logic [STATUS_W-1:0] cls;
        cls = FAULT_NONE;
        case ({coil, fb, ctype})
            3'b001, 3'b010: cls = FAULT_WELDED;
            3'b100, 3'b111: cls = FAULT_STUCK;
            default:        cls = FAULT_NONE;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

// File: hdl/rdfm_cfg_regs.sv
// APB-style configuration registers: settle delay, contact types, active count.
// Depends on rdfm_pkg for the register indexes, widths and reset values.
`default_nettype none

module rdfm_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rdfm_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rdfm_pkg::PDATA_W-1:0]  pwdata,
    output logic      [rdfm_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output rdfm_pkg::cfg_t                     cfg
);

    logic [rdfm_pkg::DELAY_W-1:0]  settle_delay_reg;
    logic [rdfm_pkg::TYPES_W-1:0]  contact_types_reg;
    logic [rdfm_pkg::ACTIVE_W-1:0] active_count_reg;
    logic                          wr_en;
    rdfm_pkg::reg_index_t          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = rdfm_pkg::reg_index_t'(paddr[3:2]);

    // Register writes complete in the access phase of a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_delay_reg  <= rdfm_pkg::SETTLE_DELAY_RST;
            contact_types_reg <= rdfm_pkg::CONTACT_TYPES_RST;
            active_count_reg  <= rdfm_pkg::ACTIVE_COUNT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                rdfm_pkg::REG_SETTLE_DELAY:
                    settle_delay_reg <= pwdata[rdfm_pkg::DELAY_W-1:0];
                rdfm_pkg::REG_CONTACT_TYPES:
                    contact_types_reg <= pwdata[rdfm_pkg::TYPES_W-1:0];
                rdfm_pkg::REG_ACTIVE_COUNT:
                    active_count_reg <= pwdata[rdfm_pkg::ACTIVE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read data is decoded straight from the address.
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            rdfm_pkg::REG_SETTLE_DELAY:
                prdata = {16'd0, settle_delay_reg};
            rdfm_pkg::REG_CONTACT_TYPES:
                prdata = {16'd0, contact_types_reg};
            rdfm_pkg::REG_ACTIVE_COUNT:
                prdata = {27'd0, active_count_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.settle_delay  = settle_delay_reg;
    assign cfg.contact_types = contact_types_reg;
    assign cfg.active_count  = active_count_reg;

endmodule

`default_nettype wire

// File: hdl/rdfm_core.sv
// Relay state (coils, sampled feedback, fault bits, settle counters, run flag)
// and the single-pass action logic. Depends on rdfm_pkg.
`default_nettype none

module rdfm_core #(
    parameter int RELAY_COUNT   = 16,
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fire,
    input  wire logic [rdfm_pkg::ACTION_W-1:0]  action,
    input  wire logic [rdfm_pkg::INDEX_W-1:0]   relay_num,
    input  wire logic                           coil_on,
    input  wire logic [rdfm_pkg::FIELD_W-1:0]   feedback_bits,
    input  rdfm_pkg::cfg_t                      cfg,
    output rdfm_pkg::result_t                   res
);

    localparam int SEL_W = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
    localparam int EXT_W = RELAY_COUNT + rdfm_pkg::FIELD_W;

    logic [RELAY_COUNT-1:0]   coil_reg, coil_next;
    logic [RELAY_COUNT-1:0]   fb_reg, fb_next;
    logic [RELAY_COUNT-1:0]   fault_reg, fault_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg  [RELAY_COUNT];
    logic [COUNTER_WIDTH-1:0] cnt_next [RELAY_COUNT];
    logic                     running_reg, running_next;

    rdfm_pkg::action_t                      act;
    logic                                   idx_valid;
    logic [SEL_W-1:0]                       sel;
    logic [COUNTER_WIDTH+rdfm_pkg::DELAY_W-1:0] delay_ext;
    logic [COUNTER_WIDTH-1:0]               delay_w;
    logic [EXT_W-1:0]                       fb_ext, types_ext, coil_ext;
    logic [RELAY_COUNT-1:0]                 types_w;
    logic [RELAY_COUNT-1:0]                 active_mask;
    logic [RELAY_COUNT-1:0]                 sampled;
    logic [RELAY_COUNT-1:0]                 sel_bit;
    logic                                   sel_settled;
    logic [rdfm_pkg::STATUS_W-1:0]          contact_w, fault_w;

    assign act       = rdfm_pkg::action_t'(action);
    assign idx_valid = {1'b0, relay_num} < 6'(RELAY_COUNT);
    assign sel       = relay_num[SEL_W-1:0];
    assign sel_bit   = RELAY_COUNT'(1) << sel;

    // Fit the fixed-width fields to the relay count and counter width.
    assign delay_ext = {{COUNTER_WIDTH{1'b0}}, cfg.settle_delay};
    assign delay_w   = delay_ext[COUNTER_WIDTH-1:0];
    assign fb_ext    = {{RELAY_COUNT{1'b0}}, feedback_bits};
    assign types_ext = {{RELAY_COUNT{1'b0}}, cfg.contact_types};
    assign types_w   = types_ext[RELAY_COUNT-1:0];

    // Relays below the active count take part in a tick.
    always_comb
    begin
        for (int i = 0; i < RELAY_COUNT; i++)
        begin
            active_mask[i] = {1'b0, cfg.active_count} > 6'(i);
        end
    end

    assign sampled     = fb_ext[RELAY_COUNT-1:0] & active_mask;
    assign sel_settled = (cnt_reg[sel] == '0);

    // Next state for each action.
    always_comb
    begin
        coil_next    = coil_reg;
        fb_next      = fb_reg;
        fault_next   = fault_reg;
        running_next = running_reg;
        for (int i = 0; i < RELAY_COUNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        unique case (act)
            rdfm_pkg::ACT_SET:
            begin
                if (idx_valid)
                begin
                    cnt_next[sel] = delay_w;
                    coil_next     = coil_on ? (coil_reg | sel_bit) : (coil_reg & ~sel_bit);
                end
            end
            rdfm_pkg::ACT_TICK:
            begin
                if (running_reg)
                begin
                    for (int i = 0; i < RELAY_COUNT; i++)
                    begin
                        if (active_mask[i] && (cnt_reg[i] != '0))
                        begin
                            cnt_next[i] = cnt_reg[i] - COUNTER_WIDTH'(1);
                        end
                    end
                    fb_next    = sampled;
                    fault_next = coil_reg ^ sampled ^ types_w;
                end
            end
            rdfm_pkg::ACT_STOP, rdfm_pkg::ACT_START:
            begin
                coil_next    = '0;
                fb_next      = '0;
                fault_next   = '0;
                running_next = (act == rdfm_pkg::ACT_START);
                for (int i = 0; i < RELAY_COUNT; i++)
                begin
                    cnt_next[i] = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Read answers come from the state before the action.
    always_comb
    begin
        contact_w = rdfm_pkg::CONTACT_OPEN;
        fault_w   = rdfm_pkg::FAULT_NONE;
        if (act == rdfm_pkg::ACT_READ_CONTACT)
        begin
            if (!idx_valid)
                contact_w = rdfm_pkg::CONTACT_INVALID;
            else if (fault_reg[sel] && sel_settled)
                contact_w = rdfm_pkg::CONTACT_ERROR;
            else if (fb_reg[sel])
                contact_w = rdfm_pkg::CONTACT_CLOSED;
            else
                contact_w = rdfm_pkg::CONTACT_OPEN;
        end
        if (act == rdfm_pkg::ACT_READ_FAULT)
        begin
            if (!idx_valid)
                fault_w = rdfm_pkg::FAULT_INVALID;
            else if (sel_settled)
                fault_w = rdfm_pkg::classify_fault(coil_reg[sel], fb_reg[sel], types_w[sel]);
            else
                fault_w = rdfm_pkg::FAULT_NONE;
        end
    end

    assign coil_ext           = {{rdfm_pkg::FIELD_W{1'b0}}, coil_next};
    assign res.coil_drive     = coil_ext[rdfm_pkg::FIELD_W-1:0];
    assign res.contact_status = contact_w;
    assign res.fault_status   = fault_w;

    // State registers advance once per transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_reg    <= '0;
            fb_reg      <= '0;
            fault_reg   <= '0;
            running_reg <= 1'b1;
            for (int i = 0; i < RELAY_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            coil_reg    <= coil_next;
            fb_reg      <= fb_next;
            fault_reg   <= fault_next;
            running_reg <= running_next;
            for (int i = 0; i < RELAY_COUNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // A stop leaves the block halted with every coil released.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (act == rdfm_pkg::ACT_STOP) |=> !running_reg && (coil_reg == '0))
        else $error("stop did not halt and clear the relays");

    // A tick while halted leaves the sampled feedback and faults alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (act == rdfm_pkg::ACT_TICK) && !running_reg
        |=> $stable(fb_reg) && $stable(fault_reg))
        else $error("tick changed state while halted");

    // Sampled feedback never holds bits beyond the active count.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (act == rdfm_pkg::ACT_TICK) |=> (fb_reg & ~$past(active_mask)) == '0)
        else $error("feedback sampled outside the active relays");

    // Without a transfer the coils hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(coil_reg))
        else $error("coils changed without a transfer");

endmodule

`default_nettype wire

// File: hdl/relay_driver_with_feedback_monitor_unit.sv
// Relay driver with feedback monitor: input stage, core and result register.
// Path: an accepted item is registered in the input stage, then in the result register.
// Throughput: one action per cycle while results drain; a result held by a stalled
// consumer blocks the input stage once that holds an item, and intake then stops.
// Reset: asynchronous, active low; coils, feedback, faults and counters clear,
// ticks are enabled, and the registers load their documented defaults.
// Depends on rdfm_pkg, rdfm_cfg_regs and rdfm_core.
`default_nettype none

module relay_driver_with_feedback_monitor_unit #(
    parameter int RELAY_COUNT   = 16,
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rdfm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [rdfm_pkg::PDATA_W-1:0]   pwdata,
    output logic      [rdfm_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rdfm_pkg::ACTION_W-1:0]  action,
    input  wire logic [rdfm_pkg::INDEX_W-1:0]   relay_num,
    input  wire logic                           coil_on,
    input  wire logic [rdfm_pkg::FIELD_W-1:0]   feedback_bits,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [rdfm_pkg::FIELD_W-1:0]   coil_drive,
    output logic      [rdfm_pkg::STATUS_W-1:0]  contact_status,
    output logic      [rdfm_pkg::STATUS_W-1:0]  fault_status
);

    rdfm_pkg::cfg_t                    cfg;
    rdfm_pkg::result_t                 res;
    rdfm_pkg::result_t                 res_reg;

    logic                              in_valid_reg;
    logic [rdfm_pkg::ACTION_W-1:0]     action_reg;
    logic [rdfm_pkg::INDEX_W-1:0]      index_reg;
    logic                              coil_on_reg;
    logic [rdfm_pkg::FIELD_W-1:0]      feedback_reg;
    logic                              out_valid_reg;
    logic                              advance;
    logic                              in_xfer;

    // The staged item moves into the result register when that has room.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    rdfm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rdfm_core #(
        .RELAY_COUNT   (RELAY_COUNT),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .action        (action_reg),
        .relay_num     (index_reg),
        .coil_on       (coil_on_reg),
        .feedback_bits (feedback_reg),
        .cfg           (cfg),
        .res           (res)
    );

    // Input stage: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input stage: payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            action_reg   <= action;
            index_reg    <= relay_num;
            coil_on_reg  <= coil_on;
            feedback_reg <= feedback_bits;
        end
    end

    // Result register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register: payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign coil_drive     = res_reg.coil_drive;
    assign contact_status = res_reg.contact_status;
    assign fault_status   = res_reg.fault_status;

    // Every item that leaves the input stage shows up as a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("staged item did not reach the result register");

    // An accepted item is held in the input stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_valid_reg)
        else $error("accepted item lost from the input stage");

    // A held result with a stalled consumer keeps the input stage blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// File: bench/relay_monitor_checker.sv
`timescale 1ns / 100ps
// Checker for the relay driver with feedback monitor: watches item, result and register
// transfers, predicts each result from its own copy of the relay state and compares it.
// Depends on rdfm_pkg for field widths, codes and the result type.

module relay_monitor_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rdfm_pkg::PADDR_W-1:0]  paddr,
    input  logic [rdfm_pkg::PDATA_W-1:0]  pwdata,
    input  logic [rdfm_pkg::PDATA_W-1:0]  prdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [rdfm_pkg::ACTION_W-1:0] action,
    input  logic [rdfm_pkg::INDEX_W-1:0]  relay_num,
    input  logic                          coil_on,
    input  logic [rdfm_pkg::FIELD_W-1:0]  feedback_bits,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [rdfm_pkg::FIELD_W-1:0]  coil_drive,
    input  logic [rdfm_pkg::STATUS_W-1:0] contact_status,
    input  logic [rdfm_pkg::STATUS_W-1:0] fault_status,
    output int                            fail_count,
    output int                            pending,
    output int                            checked
);

    localparam int RELAYS = 16;

    // Configuration as last written through the register port.
    logic [rdfm_pkg::DELAY_W-1:0]  delay_cfg;
    logic [rdfm_pkg::TYPES_W-1:0]  types_cfg;
    logic [rdfm_pkg::ACTIVE_W-1:0] active_cfg;

    // Own copy of the relay state.
    logic [rdfm_pkg::FIELD_W-1:0]  coil_q;
    logic [rdfm_pkg::FIELD_W-1:0]  feedback_q;
    logic [rdfm_pkg::FIELD_W-1:0]  fault_q;
    logic [rdfm_pkg::DELAY_W-1:0]  countdown [RELAYS];
    logic                          ticking;

    rdfm_pkg::result_t             awaited_results [$];
    int                            mismatches;
    int                            results_seen;

    // Count a failure; only the first few are described.
    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        if (mismatches < 10)
            $display("checker: %s wrong at %0t: expected %h, got %h", what, $time, want, got);
        mismatches++;
    endtask

    // Stop and start both drop every coil, sample, fault and countdown.
    task automatic clear_relays();
        coil_q     = '0;
        feedback_q = '0;
        fault_q    = '0;
        for (int i = 0; i < RELAYS; i++)
            countdown[i] = '0;
    endtask

    // Apply one action to the relay state and work out the result it gives.
    task automatic relay_step(
        input  logic [rdfm_pkg::ACTION_W-1:0] act,
        input  logic [rdfm_pkg::INDEX_W-1:0]  idx,
        input  logic                          on,
        input  logic [rdfm_pkg::FIELD_W-1:0]  fb,
        output rdfm_pkg::result_t             res
    );
        int         limit;
        logic       in_range;
        logic [3:0] pos;
        logic       coil;
        logic       seen;
        logic       ctype;
        res      = '0;
        in_range = (idx < RELAYS);
        pos      = idx[3:0];
        case (act)
            rdfm_pkg::ACT_SET:
            begin
                if (in_range)
                begin
                    countdown[pos] = delay_cfg;
                    coil_q[pos]    = on;
                end
            end
            rdfm_pkg::ACT_TICK:
            begin
                if (ticking)
                begin
                    // Counts above the relay count saturate.
                    limit      = (active_cfg > RELAYS) ? RELAYS : int'(active_cfg);
                    feedback_q = '0;
                    for (int i = 0; i < limit; i++)
                    begin
                        feedback_q[i] = fb[i];
                        if (countdown[i] != 0)
                            countdown[i] = countdown[i] - 16'd1;
                    end
                    fault_q = coil_q ^ feedback_q ^ types_cfg;
                end
            end
            rdfm_pkg::ACT_READ_CONTACT:
            begin
                if (!in_range)
                    res.contact_status = rdfm_pkg::CONTACT_INVALID;
                else if (fault_q[pos] && countdown[pos] == 0)
                    res.contact_status = rdfm_pkg::CONTACT_ERROR;
                else if (feedback_q[pos])
                    res.contact_status = rdfm_pkg::CONTACT_CLOSED;
                else
                    res.contact_status = rdfm_pkg::CONTACT_OPEN;
            end
            rdfm_pkg::ACT_READ_FAULT:
            begin
                if (!in_range)
                    res.fault_status = rdfm_pkg::FAULT_INVALID;
                else if (countdown[pos] != 0)
                    res.fault_status = rdfm_pkg::FAULT_NONE;
                else
                begin
                    // A disagreement means welded with the coil off, stuck open with it on.
                    coil  = coil_q[pos];
                    seen  = feedback_q[pos];
                    ctype = types_cfg[pos];
                    if (coil ^ seen ^ ctype)
                        res.fault_status = coil ? rdfm_pkg::FAULT_STUCK
                                                : rdfm_pkg::FAULT_WELDED;
                    else
                        res.fault_status = rdfm_pkg::FAULT_NONE;
                end
            end
            rdfm_pkg::ACT_STOP:
            begin
                clear_relays();
                ticking = 1'b0;
            end
            rdfm_pkg::ACT_START:
            begin
                clear_relays();
                ticking = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.coil_drive = coil_q;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rdfm_pkg::result_t            want;
        rdfm_pkg::result_t            got;
        logic [rdfm_pkg::PDATA_W-1:0] reg_value;
        if (!rst_n)
        begin
            delay_cfg  = rdfm_pkg::SETTLE_DELAY_RST;
            types_cfg  = rdfm_pkg::CONTACT_TYPES_RST;
            active_cfg = rdfm_pkg::ACTIVE_COUNT_RST;
            clear_relays();
            ticking = 1'b1;
            awaited_results.delete();
            mismatches   = 0;
            results_seen = 0;
            pending    <= 0;
            fail_count <= 0;
            checked    <= 0;
        end
        else
        begin
            // A result transfer is held against the oldest prediction.
            if (out_valid && out_ready)
            begin
                got.coil_drive     = coil_drive;
                got.contact_status = contact_status;
                got.fault_status   = fault_status;
                results_seen++;
                if (awaited_results.size() == 0)
                    report("result with nothing awaited, coil_drive", '0,
                           32'(got.coil_drive));
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.coil_drive != want.coil_drive)
                        report("coil_drive", 32'(want.coil_drive), 32'(got.coil_drive));
                    if (got.contact_status != want.contact_status)
                        report("contact_status", 32'(want.contact_status),
                               32'(got.contact_status));
                    if (got.fault_status != want.fault_status)
                        report("fault_status", 32'(want.fault_status),
                               32'(got.fault_status));
                end
            end

            // An item transfer adds one prediction.
            if (in_valid && in_ready)
            begin
                relay_step(action, relay_num, coil_on, feedback_bits, want);
                awaited_results.push_back(want);
            end

            // Register transfers: writes update the copy, reads are checked against it.
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        rdfm_pkg::REG_SETTLE_DELAY:
                            delay_cfg  = pwdata[rdfm_pkg::DELAY_W-1:0];
                        rdfm_pkg::REG_CONTACT_TYPES:
                            types_cfg  = pwdata[rdfm_pkg::TYPES_W-1:0];
                        rdfm_pkg::REG_ACTIVE_COUNT:
                            active_cfg = pwdata[rdfm_pkg::ACTIVE_W-1:0];
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    case (paddr[3:2])
                        rdfm_pkg::REG_SETTLE_DELAY:
                            reg_value = rdfm_pkg::PDATA_W'(delay_cfg);
                        rdfm_pkg::REG_CONTACT_TYPES:
                            reg_value = rdfm_pkg::PDATA_W'(types_cfg);
                        rdfm_pkg::REG_ACTIVE_COUNT:
                            reg_value = rdfm_pkg::PDATA_W'(active_cfg);
                        default:
                            reg_value = '0;
                    endcase
                    if (prdata != reg_value)
                        report("register read", reg_value, prdata);
                end
            end

            pending    <= awaited_results.size();
            fail_count <= mismatches;
            checked    <= results_seen;
        end
    end

endmodule

// File: bench/tb_relay_driver_with_feedback_monitor_unit.sv
`timescale 1ns / 100ps
// Top of the relay driver testbench: clock, reset, register settings, item and result
// traffic with random idling, a watchdog and the verdict.
// Depends on rdfm_pkg, relay_driver_with_feedback_monitor_unit and relay_monitor_checker.

module tb_relay_driver_with_feedback_monitor_unit;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 200;

    // Spare action codes that the block must ignore.
    localparam logic [rdfm_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [rdfm_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [rdfm_pkg::PADDR_W-1:0]  paddr         = '0;
    logic [rdfm_pkg::PDATA_W-1:0]  pwdata        = '0;
    logic [rdfm_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          in_valid      = 1'b0;
    logic                          in_ready;
    logic [rdfm_pkg::ACTION_W-1:0] action        = '0;
    logic [rdfm_pkg::INDEX_W-1:0]  relay_num     = '0;
    logic                          coil_on       = 1'b0;
    logic [rdfm_pkg::FIELD_W-1:0]  feedback_bits = '0;
    logic                          out_valid;
    logic                          out_ready     = 1'b0;
    logic [rdfm_pkg::FIELD_W-1:0]  coil_drive;
    logic [rdfm_pkg::STATUS_W-1:0] contact_status;
    logic [rdfm_pkg::STATUS_W-1:0] fault_status;

    int                            fail_count;
    int                            pending;
    int                            checked;

    // Stimulus bookkeeping: rough view of coils and run state for shaping feedback.
    logic                          calm       = 1'b0;
    logic [rdfm_pkg::FIELD_W-1:0]  coil_guess = '0;
    logic [rdfm_pkg::TYPES_W-1:0]  types_now  = rdfm_pkg::CONTACT_TYPES_RST;
    logic                          run_guess  = 1'b1;
    int                            items_sent = 0;
    int                            settings   = 0;

    relay_driver_with_feedback_monitor_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .relay_num      (relay_num),
        .coil_on        (coil_on),
        .feedback_bits  (feedback_bits),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .coil_drive     (coil_drive),
        .contact_status (contact_status),
        .fault_status   (fault_status)
    );

    relay_monitor_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .relay_num      (relay_num),
        .coil_on        (coil_on),
        .feedback_bits  (feedback_bits),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .coil_drive     (coil_drive),
        .contact_status (contact_status),
        .fault_status   (fault_status),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle cycles before the next transfer on either side.
    function automatic int idle_draw();
        return calm ? 0 : int'($urandom_range(0, 9));
    endfunction

    // One register access: setup cycle, then access cycle until pready.
    task automatic reg_access(input logic wr, input rdfm_pkg::reg_index_t which,
                              input logic [rdfm_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write all three registers with junk in the unused upper bits, then read them back.
    task automatic configure(input logic [rdfm_pkg::DELAY_W-1:0] delay,
                             input logic [rdfm_pkg::TYPES_W-1:0] types,
                             input logic [rdfm_pkg::ACTIVE_W-1:0] active);
        reg_access(1'b1, rdfm_pkg::REG_SETTLE_DELAY, {16'($urandom()), delay});
        reg_access(1'b1, rdfm_pkg::REG_CONTACT_TYPES, {16'($urandom()), types});
        reg_access(1'b1, rdfm_pkg::REG_ACTIVE_COUNT, {27'($urandom()), active});
        reg_access(1'b0, rdfm_pkg::REG_SETTLE_DELAY, '0);
        reg_access(1'b0, rdfm_pkg::REG_CONTACT_TYPES, '0);
        reg_access(1'b0, rdfm_pkg::REG_ACTIVE_COUNT, '0);
        types_now = types;
        settings++;
    endtask

    // Offer one item, hold it until the transfer, then idle as drawn.
    task automatic send_item(input logic [rdfm_pkg::ACTION_W-1:0] act,
                             input logic [rdfm_pkg::INDEX_W-1:0] idx,
                             input logic on, input logic [rdfm_pkg::FIELD_W-1:0] fb);
        int gap;
        in_valid      <= 1'b1;
        action        <= act;
        relay_num     <= idx;
        coil_on       <= on;
        feedback_bits <= fb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // Ticks while stopped and spare actions do nothing, so they are not counted.
        if (!((act == rdfm_pkg::ACT_TICK && !run_guess) || act == ACT_SPARE_LO
              || act == ACT_SPARE_HI))
            items_sent++;
        if (act == rdfm_pkg::ACT_SET && idx < 16)
            coil_guess[idx[3:0]] = on;
        else if (act == rdfm_pkg::ACT_STOP || act == rdfm_pkg::ACT_START)
        begin
            coil_guess = '0;
            run_guess  = (act == rdfm_pkg::ACT_START);
        end
        gap = idle_draw();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every predicted result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic: valid indexes, feedback close to the healthy pattern.
    task automatic random_item();
        int                            pick;
        logic [rdfm_pkg::ACTION_W-1:0] act;
        logic [rdfm_pkg::INDEX_W-1:0]  idx;
        logic [rdfm_pkg::FIELD_W-1:0]  fb;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            act = rdfm_pkg::ACT_SET;
        else if (pick < 60)
            act = rdfm_pkg::ACT_TICK;
        else if (pick < 75)
            act = rdfm_pkg::ACT_READ_CONTACT;
        else if (pick < 90)
            act = rdfm_pkg::ACT_READ_FAULT;
        else if (pick < 92)
            act = rdfm_pkg::ACT_STOP;
        else if (pick < 97)
            act = rdfm_pkg::ACT_START;
        else
            act = ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
        if ($urandom_range(0, 9) != 0)
            idx = 5'($urandom_range(0, 15));
        else
            idx = 5'($urandom_range(16, 31));
        if ($urandom_range(0, 9) < 7)
            fb = coil_guess ^ types_now ^ 16'($urandom() & $urandom() & $urandom());
        else
            fb = 16'($urandom());
        send_item(act, idx, 1'($urandom_range(0, 1)), fb);
    endtask

    // Watchdog: too long with no transfer on either channel ends the run.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results awaited",
                 IDLE_LIMIT, pending);
        $display("tb: failure");
        $finish;
    end

    // Result side: stall a drawn number of cycles before taking each result.
    initial
    begin : receiver
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = idle_draw();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int                            target;
        int                            pick;
        logic [rdfm_pkg::DELAY_W-1:0]  delay;
        logic [rdfm_pkg::TYPES_W-1:0]  types;
        logic [rdfm_pkg::ACTIVE_W-1:0] active;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: unsettled reads, bad indexes and spare actions.
        send_item(rdfm_pkg::ACT_SET, 5'd0, 1'b1, '0);
        send_item(rdfm_pkg::ACT_TICK, 5'd0, 1'b0, 16'hFFFF);
        send_item(rdfm_pkg::ACT_READ_CONTACT, 5'd0, 1'b0, '0);
        send_item(rdfm_pkg::ACT_READ_FAULT, 5'd0, 1'b0, '0);
        send_item(rdfm_pkg::ACT_READ_CONTACT, 5'd31, 1'b1, 16'hFFFF);
        send_item(rdfm_pkg::ACT_READ_FAULT, 5'd16, 1'b0, '0);
        send_item(rdfm_pkg::ACT_SET, 5'd20, 1'b1, '0);
        send_item(ACT_SPARE_LO, 5'd1, 1'b1, 16'h5555);
        send_item(ACT_SPARE_HI, 5'd2, 1'b0, 16'hAAAA);
        drain();

        // One-tick settle, oversized active count: stuck open, welded, stopped ticks.
        configure(16'd1, 16'h00FF, 5'd31);
        send_item(rdfm_pkg::ACT_SET, 5'd15, 1'b1, '0);
        send_item(rdfm_pkg::ACT_SET, 5'd3, 1'b0, '0);
        send_item(rdfm_pkg::ACT_TICK, 5'd0, 1'b0, 16'h0000);
        send_item(rdfm_pkg::ACT_READ_FAULT, 5'd15, 1'b0, '0);
        send_item(rdfm_pkg::ACT_READ_CONTACT, 5'd15, 1'b0, '0);
        send_item(rdfm_pkg::ACT_READ_FAULT, 5'd3, 1'b0, '0);
        send_item(rdfm_pkg::ACT_STOP, 5'd0, 1'b0, '0);
        send_item(rdfm_pkg::ACT_TICK, 5'd0, 1'b0, 16'hFFFF);
        send_item(rdfm_pkg::ACT_SET, 5'd2, 1'b1, '0);
        send_item(rdfm_pkg::ACT_READ_FAULT, 5'd2, 1'b0, '0);
        send_item(rdfm_pkg::ACT_START, 5'd0, 1'b0, '0);
        drain();

        // Zero delay and zero active count, then the longest delay.
        configure(16'd0, 16'hFFFF, 5'd0);
        send_item(rdfm_pkg::ACT_SET, 5'd7, 1'b1, '0);
        send_item(rdfm_pkg::ACT_TICK, 5'd0, 1'b0, 16'hFFFF);
        send_item(rdfm_pkg::ACT_READ_CONTACT, 5'd7, 1'b0, '0);
        send_item(rdfm_pkg::ACT_READ_FAULT, 5'd7, 1'b0, '0);
        drain();
        configure(16'hFFFF, 16'h0000, 5'd16);
        send_item(rdfm_pkg::ACT_SET, 5'd9, 1'b1, '0);
        send_item(rdfm_pkg::ACT_TICK, 5'd0, 1'b0, 16'hFFFF);
        send_item(rdfm_pkg::ACT_READ_FAULT, 5'd9, 1'b0, '0);

        // Random phases, each under a fresh register setting.
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            drain();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                delay = '0;
            else if (pick == 1)
                delay = 16'hFFFF;
            else if (pick == 2)
                delay = 16'($urandom());
            else
                delay = 16'($urandom_range(1, 6));
            pick = $urandom_range(0, 5);
            if (pick == 0)
                types = '0;
            else if (pick == 1)
                types = 16'hFFFF;
            else
                types = 16'($urandom());
            pick = $urandom_range(0, 7);
            if (pick == 0)
                active = '0;
            else if (pick == 1)
                active = 5'd31;
            else if (pick == 2)
                active = 5'($urandom_range(0, 31));
            else if (pick < 5)
                active = 5'($urandom_range(8, 16));
            else
                active = 5'd16;
            configure(delay, types, active);
            calm = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS)
            begin
                random_item();
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
        end
        calm = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        $display("summary: %0d effective items under %0d register settings, %0d results checked",
                 items_sent, settings, checked);
        if (pending != 0)
            $display("summary: %0d predicted results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
